FILE: sv/clfv_pkg.sv
package clfv_pkg;

  localparam int MAX_LINE_DEF = 256;

  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_VERB,
    PH_GAP,
    PH_KEY,
    PH_VALUE,
    PH_DROP
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_EMPTY,
    ST_BAD_VERB,
    ST_NO_EQUALS,
    ST_BAD_KEY,
    ST_OVERLONG
  } status_t;

  typedef struct packed {
    phase_t     phase;
    status_t    err;
    logic       tok_ok;
    logic       tok_ne;
    logic [7:0] fields;
  } line_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] field_count;
    logic [8:0] line_length;
  } verdict_t;

  localparam line_t LINE_CLEAR = '{
    phase:  PH_LEAD,
    err:    ST_OK,
    tok_ok: 1'b1,
    tok_ne: 1'b0,
    fields: 8'd0
  };

  function automatic logic bare_char(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39) || c == CH_DASH || c == CH_UNDER ||
           c == CH_DOT;
  endfunction

  // One ordinary byte of a line against the parse state.
  function automatic line_t parse_byte(line_t st, logic [7:0] c);
    line_t r;
    r = st;
    if (st.err == ST_OK) begin
      unique case (st.phase)
        PH_LEAD: begin
          if (c != CH_SPACE) begin
            r.phase  = PH_VERB;
            r.tok_ok = bare_char(c);
            r.tok_ne = 1'b1;
          end
        end
        PH_VERB: begin
          if (c == CH_SPACE) begin
            if (st.tok_ok && st.tok_ne) r.phase = PH_GAP;
            else r.err = ST_BAD_VERB;
          end else begin
            r.tok_ok = st.tok_ok && bare_char(c);
          end
        end
        PH_GAP: begin
          if (c == CH_EQ) begin
            r.err = ST_BAD_KEY;
          end else if (c != CH_SPACE) begin
            r.phase  = PH_KEY;
            r.tok_ok = bare_char(c);
            r.tok_ne = 1'b1;
          end
        end
        PH_KEY: begin
          if (c == CH_SPACE) begin
            r.err = ST_NO_EQUALS;
          end else if (c == CH_EQ) begin
            if (st.tok_ok && st.tok_ne) begin
              if (st.fields != 8'hFF) r.fields = st.fields + 8'd1;
              r.phase = PH_VALUE;
            end else begin
              r.err = ST_BAD_KEY;
            end
          end else begin
            r.tok_ok = st.tok_ok && bare_char(c);
          end
        end
        PH_VALUE: begin
          if (c == CH_SPACE) r.phase = PH_GAP;
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  function automatic status_t final_status(line_t st);
    status_t s;
    s = ST_OK;
    if (st.err != ST_OK) begin
      s = st.err;
    end else begin
      unique case (st.phase)
        PH_LEAD: s = ST_EMPTY;
        PH_VERB: s = (st.tok_ok && st.tok_ne) ? ST_OK : ST_BAD_VERB;
        PH_KEY:  s = ST_NO_EQUALS;
        default: s = ST_OK;
      endcase
    end
    return s;
  endfunction

endpackage

FILE: sv/clfv_line_tracker.sv
module clfv_line_tracker
  import clfv_pkg::*;
#(
  parameter int MAX_LINE = MAX_LINE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] step_byte,
  output verdict_t   verdict
);

  localparam int CW = $clog2(MAX_LINE + 1);
  localparam int LW = (CW > 9) ? CW : 9;

  line_t         line_r, line_nxt, line_mid;
  logic          pend_r, pend_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] len_sel;
  logic [LW-1:0] len_ext;

  // Next state of the line parser.
  always_comb begin
    line_nxt = line_r;
    pend_nxt = pend_r;
    cnt_nxt  = cnt_r;
    line_mid = pend_r ? parse_byte(line_r, CH_CR) : line_r;
    if (step) begin
      priority if (step_byte == CH_NL) begin
        line_nxt = LINE_CLEAR;
        pend_nxt = 1'b0;
        cnt_nxt  = '0;
      end else if (line_r.phase == PH_DROP) begin
        line_nxt = line_r;
      end else if (cnt_r >= CW'(MAX_LINE)) begin
        line_nxt.phase = PH_DROP;
        pend_nxt       = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
        if (step_byte == CH_CR) begin
          pend_nxt = 1'b1;
        end else begin
          // held returns act as a single non-token byte
          line_nxt = parse_byte(line_mid, step_byte);
          pend_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r <= LINE_CLEAR;
      pend_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      line_r <= line_nxt;
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Verdict for a newline arriving now.
  always_comb begin
    len_sel = (line_r.phase == PH_DROP) ? CW'(MAX_LINE) : cnt_r;
    len_ext = LW'(len_sel);
    verdict.line_length = (len_ext > LW'(511)) ? 9'h1FF : len_ext[8:0];
    if (line_r.phase == PH_DROP) begin
      verdict.status      = ST_OVERLONG;
      verdict.field_count = 8'd0;
    end else begin
      verdict.status      = final_status(line_r);
      verdict.field_count = line_r.fields;
    end
  end

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    line_r.phase == PH_DROP |-> cnt_r == CW'(MAX_LINE))
    else $error("dropped line without full count");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    line_r.err != ST_OK && step && step_byte != CH_NL |=> $stable(line_r.err))
    else $error("first error overwritten");

  a_nl_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && step_byte == CH_NL |=> cnt_r == '0 && !pend_r && line_r.fields == 8'd0)
    else $error("line state not cleared at newline");

endmodule

FILE: sv/command_line_framer_validator_core.sv
// Command line framer / validator.
// Input channel: one byte per word on in_byte, in_valid / in_stall.
// Output channel: one verdict word per line (out_status, out_field_count,
// out_line_length) on out_valid / out_stall; other bytes produce nothing.
// A byte accepted at one edge is held in an input register and parsed in the
// next cycle, unless it is a newline held there by a stall; the verdict for
// a newline is registered as it is parsed, which raises out_valid.
// Throughput is one byte per cycle while no newline stalls: the parser is a
// short combinational step between the input register and the line-state /
// result registers. When the receiver stalls with a verdict waiting, ordinary
// bytes keep flowing; only a following newline waits in the input register,
// which then raises in_stall until the output register frees.
// Reset (rst_n low, synchronous) empties both registers and returns the
// parser to the start of a line.
module command_line_framer_validator_core
  import clfv_pkg::*;
#(
  parameter int MAX_LINE = MAX_LINE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_status,
  output logic [7:0] out_field_count,
  output logic [8:0] out_line_length
);

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_nl;
  logic       s1_go;
  logic       out_free;
  verdict_t   verdict;
  verdict_t   out_r;
  logic       out_valid_r;

  assign s1_nl    = s1_byte_r == CH_NL;
  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && (!s1_nl || out_free);
  assign in_stall = s1_valid_r && !s1_go;

  clfv_line_tracker #(
    .MAX_LINE(MAX_LINE)
  ) u_tracker (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (s1_go),
    .step_byte(s1_byte_r),
    .verdict  (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) s1_byte_r <= in_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_nl) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_nl) out_r <= verdict;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_r.status;
  assign out_field_count = out_r.field_count;
  assign out_line_length = out_r.line_length;

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && s1_nl && out_valid_r)
    else $error("input stalled without a blocked newline");

  a_nl_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_nl |=> out_valid_r)
    else $error("newline word gave no verdict");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !(s1_go && s1_nl))
    else $error("verdict overwritten while stalled");

endmodule
